// File: rtl/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is asserted
`define STQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");

// clocked assertion that also holds during reset
`define STQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

// File: rtl/stq_pkg.sv
package stq_pkg;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [2:0] KIND_ADDED    = 3'd0;
  localparam logic [2:0] KIND_REJECTED = 3'd1;
  localparam logic [2:0] KIND_FULL     = 3'd2;
  localparam logic [2:0] KIND_REMOVED  = 3'd3;
  localparam logic [2:0] KIND_EXPIRED  = 3'd4;

  localparam logic [4:0] MAX_RESULTS = 5'd16;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [31:0] due;
    logic [15:0] id;
    logic [23:0] period;
    logic        rep;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_INS_START,
    ST_A_RD,
    ST_A_CMP,
    ST_S_RD,
    ST_S_WR,
    ST_INS,
    ST_R_RD,
    ST_R_CHK,
    ST_T_RD,
    ST_T_CHK,
    ST_P_RD,
    ST_P_WR
  } state_t;

  function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// File: rtl/sorted_timer_queue.sv
// Timer table kept in due-time order in one single-port-style memory with a
// registered read. Items are taken one at a time. Each table step is a read
// followed by a modify or write. An add scans entries for the insert point,
// then shifts the later entries up; a remove reads every entry and writes
// back the ones it keeps; a tick checks the front entry and, on each expiry,
// shifts the rest of the table forward and runs an add for a re-armed
// repeating timer. Results leave through an output register, one per cycle
// at most; a stalled result holds the sequencer at its next result until it
// is taken.
module sorted_timer_queue #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_timer_id,
  input  logic [23:0] in_interval,
  input  logic        in_repeat_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_id,
  output logic [4:0]  out_removed_count,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stq_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = (CW > 5) ? CW : 5;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  entry_t        mem_wd;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [CW-1:0] idx_r, idx_nxt, pos_r, pos_nxt, wi_r, wi_nxt, count_r, count_nxt;
  logic [RW-1:0] removed_r, removed_nxt;
  logic [31:0]   time_r, time_nxt;
  entry_t        ent_r, ent_nxt;
  logic [4:0]    nres_r, nres_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [15:0]   pend_id_r, pend_id_nxt;
  logic          is_tick_r, is_tick_nxt;
  logic [2:0]    res_kind_r, res_kind_nxt;
  logic [15:0]   res_id_r, res_id_nxt;
  logic [4:0]    res_cnt_r, res_cnt_nxt;
  logic          res_last_r, res_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_kind_r, out_kind_nxt;
  logic [15:0]   out_id_r, out_id_nxt;
  logic [4:0]    out_cnt_r, out_cnt_nxt;
  logic          out_last_r, out_last_nxt;
  logic [15:0]   limit_r;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_id    = out_id_r;
  assign out_removed_count = out_cnt_r;
  assign out_last  = out_last_r;
  assign pready    = 1'b1;
  assign prdata    = {16'd0, limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_r <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      count_r     <= '0;
      time_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    wi_r       <= wi_nxt;
    removed_r  <= removed_nxt;
    ent_r      <= ent_nxt;
    nres_r     <= nres_nxt;
    pend_id_r  <= pend_id_nxt;
    is_tick_r  <= is_tick_nxt;
    res_kind_r <= res_kind_nxt;
    res_id_r   <= res_id_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_last_r <= res_last_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    wi_nxt       = wi_r;
    count_nxt    = count_r;
    removed_nxt  = removed_r;
    time_nxt     = time_r;
    ent_nxt      = ent_r;
    nres_nxt     = nres_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    is_tick_nxt  = is_tick_r;
    res_kind_nxt = res_kind_r;
    res_id_nxt   = res_id_r;
    res_cnt_nxt  = res_cnt_r;
    res_last_nxt = res_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_cnt_nxt  = out_cnt_r;
    out_last_nxt = out_last_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = rd_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_TICK: begin
              time_nxt    = time_r + 32'd1;
              nres_nxt    = '0;
              pend_v_nxt  = 1'b0;
              is_tick_nxt = 1'b1;
              state_nxt   = ST_T_RD;
            end
            ACT_ADD: begin
              is_tick_nxt    = 1'b0;
              ent_nxt.due    = time_r + {8'd0, in_interval};
              ent_nxt.id     = in_timer_id;
              ent_nxt.period = in_interval;
              ent_nxt.rep    = in_repeat_req;
              res_id_nxt     = in_timer_id;
              res_cnt_nxt    = '0;
              res_last_nxt   = 1'b1;
              ret_nxt        = ST_IDLE;
              if (!in_repeat_req && (in_timer_id >= limit_r)) begin
                res_kind_nxt = KIND_REJECTED;
                state_nxt    = ST_EMIT;
              end else if (count_r == CW'(TABLE_DEPTH)) begin
                res_kind_nxt = KIND_FULL;
                state_nxt    = ST_EMIT;
              end else begin
                state_nxt = ST_INS_START;
              end
            end
            ACT_REMOVE: begin
              ent_nxt.id  = in_timer_id;
              idx_nxt     = '0;
              wi_nxt      = '0;
              removed_nxt = '0;
              state_nxt   = ST_R_RD;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_id_nxt    = res_id_r;
          out_cnt_nxt   = res_cnt_r;
          out_last_nxt  = res_last_r;
          state_nxt     = ret_r;
        end
      end
      ST_INS_START: begin
        idx_nxt = '0;
        if (count_r == '0) begin
          pos_nxt   = '0;
          state_nxt = ST_INS;
        end else begin
          state_nxt = ST_A_RD;
        end
      end
      ST_A_RD: begin
        mem_re    = 1'b1;
        mem_ra    = idx_r[AW-1:0];
        state_nxt = ST_A_CMP;
      end
      ST_A_CMP: begin
        if (is_later(rd_r.due, ent_r.due)) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          state_nxt = ST_S_RD;
        end else if (idx_r + CW'(1) == count_r) begin
          pos_nxt   = count_r;
          idx_nxt   = count_r;
          state_nxt = ST_S_RD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_A_RD;
        end
      end
      ST_S_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = ST_INS;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = AW'(idx_r - CW'(1));
          state_nxt = ST_S_WR;
        end
      end
      ST_S_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = rd_r;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = ST_S_RD;
      end
      ST_INS: begin
        mem_we    = 1'b1;
        mem_wa    = pos_r[AW-1:0];
        mem_wd    = ent_r;
        count_nxt = count_r + CW'(1);
        if (is_tick_r) begin
          state_nxt = ST_T_RD;
        end else begin
          res_kind_nxt = KIND_ADDED;
          ret_nxt      = ST_IDLE;
          state_nxt    = ST_EMIT;
        end
      end
      ST_R_RD: begin
        if (idx_r == count_r) begin
          count_nxt    = wi_r;
          res_kind_nxt = KIND_REMOVED;
          res_id_nxt   = ent_r.id;
          res_cnt_nxt  = (removed_r > RW'(31)) ? 5'd31 : removed_r[4:0];
          res_last_nxt = 1'b1;
          ret_nxt      = ST_IDLE;
          state_nxt    = ST_EMIT;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = idx_r[AW-1:0];
          state_nxt = ST_R_CHK;
        end
      end
      ST_R_CHK: begin
        if (rd_r.id == ent_r.id) begin
          removed_nxt = removed_r + RW'(1);
        end else begin
          mem_we = 1'b1;
          mem_wa = wi_r[AW-1:0];
          mem_wd = rd_r;
          wi_nxt = wi_r + CW'(1);
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = ST_R_RD;
      end
      ST_T_RD: begin
        if ((nres_r == MAX_RESULTS) || (count_r == '0)) begin
          res_kind_nxt = KIND_EXPIRED;
          res_id_nxt   = pend_id_r;
          res_cnt_nxt  = '0;
          res_last_nxt = 1'b1;
          ret_nxt      = ST_IDLE;
          state_nxt    = pend_v_r ? ST_EMIT : ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = '0;
          state_nxt = ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        res_kind_nxt = KIND_EXPIRED;
        res_id_nxt   = pend_id_r;
        res_cnt_nxt  = '0;
        if (is_later(time_r, rd_r.due)) begin
          ent_nxt.due    = time_r + {8'd0, rd_r.period};
          ent_nxt.id     = rd_r.id;
          ent_nxt.period = rd_r.period;
          ent_nxt.rep    = rd_r.rep;
          pend_id_nxt    = rd_r.id;
          pend_v_nxt     = 1'b1;
          nres_nxt       = nres_r + 5'd1;
          idx_nxt        = CW'(1);
          res_last_nxt   = 1'b0;
          ret_nxt        = ST_P_RD;
          state_nxt      = pend_v_r ? ST_EMIT : ST_P_RD;
        end else begin
          res_last_nxt = 1'b1;
          ret_nxt      = ST_IDLE;
          state_nxt    = pend_v_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_P_RD: begin
        if (idx_r == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ent_r.rep ? ST_INS_START : ST_T_RD;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = idx_r[AW-1:0];
          state_nxt = ST_P_WR;
        end
      end
      ST_P_WR: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(idx_r - CW'(1));
        mem_wd    = rd_r;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = ST_P_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/stq_checker.sv
`include "assert_macros.svh"

module stq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [4:0]  out_removed_count,
  input logic        out_last,
  input logic        pready
);
  import stq_pkg::*;

  logic cmd_act;

  // unused action codes leave the block idle
  assign cmd_act = (in_action == ACT_TICK) || (in_action == ACT_ADD) ||
                   (in_action == ACT_REMOVE);

  `STQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)
  `STQ_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_kind))
  `STQ_ASSERT(a_count_kind, clk, rst_n, out_valid && out_kind != KIND_REMOVED |-> out_removed_count == 5'd0)
  `STQ_ASSERT(a_single_last, clk, rst_n, out_valid && out_kind != KIND_EXPIRED |-> out_last)
  `STQ_ASSERT(a_busy, clk, rst_n, in_valid && in_ready && cmd_act |=> !in_ready && pready)

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_action         (in_action),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_removed_count (out_removed_count),
  .out_last          (out_last),
  .pready            (pready)
);
